[src/telemetry_frame_receiver_macros.svh]
// ---------------------------------------------------------------------------
// telemetry frame receiver assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_RECEIVER_MACROS_SVH
`define TELEMETRY_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, disabled in reset
`define TFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfr same-cycle check failed");

// next-cycle implication, disabled in reset
`define TFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfr next-cycle check failed");

`endif

[src/tfr_pkg.sv]
// ---------------------------------------------------------------------------
// tfr_pkg
// shared types, header codes and frame length helper of the telemetry
// frame receiver
// ---------------------------------------------------------------------------
package tfr_pkg;

  // default depth of the payload store
  localparam int PAYLOAD_BYTES_DEF = 14;

  // byte position counter width
  localparam int POS_W = 5;

  // header and frame type bytes
  localparam logic [7:0] HDR_START  = 8'h24;
  localparam logic [7:0] HDR_SECOND = 8'h54;
  localparam logic [7:0] TYPE_G     = 8'h47;
  localparam logic [7:0] TYPE_A     = 8'h41;
  localparam logic [7:0] TYPE_S     = 8'h53;

  // frame kind codes as reported on the result
  localparam logic [1:0] KIND_G = 2'd0;
  localparam logic [1:0] KIND_A = 2'd1;
  localparam logic [1:0] KIND_S = 2'd2;

  // payload lengths per kind
  localparam logic [POS_W-1:0] LEN_G = 5'd14;
  localparam logic [POS_W-1:0] LEN_A = 5'd6;
  localparam logic [POS_W-1:0] LEN_S = 5'd7;

  // operation handed from the front to the back
  typedef enum logic [0:0] {
    OP_STORE = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  // one queue entry
  typedef struct packed {
    op_t              op;
    logic [1:0]       kind;
    logic [POS_W-1:0] idx;
    logic [7:0]       data;
  } entry_t;

  // payload length of a frame kind
  function automatic logic [POS_W-1:0] payload_len(input logic [1:0] kind);
    logic [POS_W-1:0] len;
    case (kind)
      KIND_G:  len = LEN_G;
      KIND_A:  len = LEN_A;
      default: len = LEN_S;
    endcase
    return len;
  endfunction

endpackage

[src/tfr_front.sv]
// ---------------------------------------------------------------------------
// tfr_front
// header hunt and byte classification; emits store and check operations
// ---------------------------------------------------------------------------
module tfr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       rx_byte,
  output logic             push,
  output tfr_pkg::entry_t  push_entry
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_DOLLAR = 4'b0010,
    PH_TYPE   = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_t;

  phase_t                    phase_r, phase_nxt;
  logic [1:0]                kind_r, kind_nxt;
  logic [tfr_pkg::POS_W-1:0] pos_r, pos_nxt;

  // next state and operation decode
  always_comb begin
    phase_nxt       = phase_r;
    kind_nxt        = kind_r;
    pos_nxt         = pos_r;
    push            = 1'b0;
    push_entry.op   = tfr_pkg::OP_STORE;
    push_entry.kind = kind_r;
    push_entry.idx  = pos_r;
    push_entry.data = rx_byte;
    if (fire) begin
      case (phase_r)
        PH_IDLE: begin
          if (rx_byte == tfr_pkg::HDR_START) phase_nxt = PH_DOLLAR;
        end
        PH_DOLLAR: begin
          phase_nxt = (rx_byte == tfr_pkg::HDR_SECOND) ? PH_TYPE : PH_IDLE;
        end
        PH_TYPE: begin
          phase_nxt = PH_DATA;
          pos_nxt   = '0;
          if (rx_byte == tfr_pkg::TYPE_G) begin
            kind_nxt = tfr_pkg::KIND_G;
          end else if (rx_byte == tfr_pkg::TYPE_A) begin
            kind_nxt = tfr_pkg::KIND_A;
          end else if (rx_byte == tfr_pkg::TYPE_S) begin
            kind_nxt = tfr_pkg::KIND_S;
          end else begin
            phase_nxt = PH_IDLE;
            pos_nxt   = pos_r;
          end
        end
        PH_DATA: begin
          push = 1'b1;
          if (pos_r < tfr_pkg::payload_len(kind_r)) begin
            pos_nxt = pos_r + 1'b1;
          end else begin
            // checksum byte closes the frame
            push_entry.op = tfr_pkg::OP_CHECK;
            phase_nxt     = PH_IDLE;
            pos_nxt       = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= tfr_pkg::KIND_G;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

[src/tfr_queue.sv]
// ---------------------------------------------------------------------------
// tfr_queue
// two-entry queue of operations between front and back
// ---------------------------------------------------------------------------
module tfr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tfr_pkg::entry_t  push_entry,
  output logic             full,
  output logic             pop_valid,
  output tfr_pkg::entry_t  pop_entry,
  input  logic             pop
);

  tfr_pkg::entry_t slot_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            do_push, do_pop;

  // status and head of queue
  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_entry = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 2'd1;
    if (do_pop && !do_push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule

[src/tfr_back.sv]
// ---------------------------------------------------------------------------
// tfr_back
// payload store, checksum, position decode, frame counters and result
// register
// ---------------------------------------------------------------------------
module tfr_back #(
  parameter int PAYLOAD_BYTES = tfr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tfr_pkg::entry_t    q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_frame_type,
  output logic               out_checksum_ok,
  output logic               out_position_valid,
  output logic signed [31:0] out_latitude,
  output logic signed [31:0] out_longitude,
  output logic signed [31:0] out_altitude,
  output logic [31:0]        out_good_frames,
  output logic [31:0]        out_bad_frames
);

  localparam int IDX_W = $clog2(PAYLOAD_BYTES);

  logic [7:0]  store_r [PAYLOAD_BYTES];
  logic [7:0]  xor_r, xor_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] bad_r, bad_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  type_r;
  logic        ok_r, pos_r;
  logic [31:0] lat_r, lon_r, alt_r;
  logic        is_check, load_out, ok_now, pos_now;
  logic [7:0]  xor_now;

  // a check waits for a free result register, a store never waits
  assign is_check = (q_entry.op == tfr_pkg::OP_CHECK);
  assign q_pop    = q_valid && (!is_check || !out_valid_r || !out_stall);
  assign load_out = q_pop && is_check;

  assign xor_now = xor_r ^ q_entry.data;
  assign ok_now  = (xor_now == 8'h00);
  assign pos_now = ok_now && (q_entry.kind == tfr_pkg::KIND_G);

  // checksum and counters
  always_comb begin
    xor_nxt       = xor_r;
    good_nxt      = good_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop) begin
      xor_nxt = is_check ? 8'h00 : xor_now;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      if (ok_now) good_nxt = good_r + 32'd1;
      else        bad_nxt  = bad_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r       <= 8'h00;
      good_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      xor_r       <= xor_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (q_pop && !is_check) store_r[q_entry.idx[IDX_W-1:0]] <= q_entry.data;
  end

  // result register with little-endian position decode
  always_ff @(posedge clk) begin
    if (load_out) begin
      type_r <= q_entry.kind;
      ok_r   <= ok_now;
      pos_r  <= pos_now;
      lat_r  <= pos_now ? {store_r[3], store_r[2], store_r[1], store_r[0]} : 32'd0;
      lon_r  <= pos_now ? {store_r[7], store_r[6], store_r[5], store_r[4]} : 32'd0;
      alt_r  <= pos_now ? {store_r[12], store_r[11], store_r[10], store_r[9]} : 32'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_type     = type_r;
  assign out_checksum_ok    = ok_r;
  assign out_position_valid = pos_r;
  assign out_latitude       = lat_r;
  assign out_longitude      = lon_r;
  assign out_altitude       = alt_r;
  assign out_good_frames    = good_r;
  assign out_bad_frames     = bad_r;

endmodule

[src/telemetry_frame_receiver.sv]
// ---------------------------------------------------------------------------
// telemetry_frame_receiver
// byte-serial receiver for '$','T' framed G, A and S telemetry frames
// ---------------------------------------------------------------------------
// Takes one received byte per item and sustains one item per clock while
// in_stall is low. Header bytes are consumed by the front hunter; payload
// and checksum bytes pass through a two-entry queue to the back, which
// stores the payload, folds the checksum and fills the result register.
// The checksum byte is registered in the queue and then loaded into the
// result register as soon as that register is free. in_stall rises only
// when the queue is full, which happens when a result sits unread in the
// output register, the next checksum byte waits at the head of the queue
// and one more byte has come in behind it.
module telemetry_frame_receiver #(
  parameter int PAYLOAD_BYTES = tfr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_frame_type,
  output logic               out_checksum_ok,
  output logic               out_position_valid,
  output logic signed [31:0] out_latitude,
  output logic signed [31:0] out_longitude,
  output logic signed [31:0] out_altitude,
  output logic [31:0]        out_good_frames,
  output logic [31:0]        out_bad_frames
);

  logic            q_full, fire, push, q_valid, q_pop;
  tfr_pkg::entry_t push_entry, q_entry;

  // accept whenever the queue has room
  assign in_stall = q_full;
  assign fire     = in_valid && !q_full;

  tfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .rx_byte    (in_rx_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  tfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .pop        (q_pop)
  );

  tfr_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_entry            (q_entry),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_type     (out_frame_type),
    .out_checksum_ok    (out_checksum_ok),
    .out_position_valid (out_position_valid),
    .out_latitude       (out_latitude),
    .out_longitude      (out_longitude),
    .out_altitude       (out_altitude),
    .out_good_frames    (out_good_frames),
    .out_bad_frames     (out_bad_frames)
  );

endmodule

[src/tfr_checker.sv]
// ---------------------------------------------------------------------------
// tfr_checker
// port-level checks of the telemetry frame receiver, bound to the top level
// ---------------------------------------------------------------------------
`include "telemetry_frame_receiver_macros.svh"

module tfr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_frame_type,
  input logic               out_checksum_ok,
  input logic               out_position_valid,
  input logic signed [31:0] out_latitude,
  input logic signed [31:0] out_longitude,
  input logic signed [31:0] out_altitude,
  input logic [31:0]        out_good_frames,
  input logic [31:0]        out_bad_frames
);

  // a stalled result stays put
  `TFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_good_frames) && $stable(out_bad_frames) && $stable(out_latitude))

  // position only from a good gps frame
  `TFR_ASSERT_NOW(a_pos_good_g, clk, rst_n, out_valid && out_position_valid, out_checksum_ok && (out_frame_type == tfr_pkg::KIND_G))

  // no position means zeroed coordinates
  `TFR_ASSERT_NOW(a_pos_zero, clk, rst_n, out_valid && !out_position_valid, (out_latitude == 32'sd0) && (out_longitude == 32'sd0) && (out_altitude == 32'sd0))

  // input backs up only behind a held result
  `TFR_ASSERT_NOW(a_stall_held_result, clk, rst_n, in_stall, out_valid)

endmodule

bind telemetry_frame_receiver tfr_checker u_tfr_checker (.*);

[tb/tb_telemetry_frame_receiver.sv]
// ---------------------------------------------------------------------------
// tb_telemetry_frame_receiver
// Self-checking bench for the byte-serial telemetry frame receiver. A short
// directed table covers the header hunt, field extremes and a bad checksum.
// Random frames with random content, noise and broken headers follow; a
// built-in frame decoder predicts their results, each directed row holds
// its own. Results are compared field by field while both sides idle and stall.
// ---------------------------------------------------------------------------
module tb_telemetry_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  // one finished frame as reported by the block
  typedef struct packed {
    logic [1:0]         kind;
    logic               ok;
    logic               pos;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [31:0] alt;
    logic [31:0]        good;
    logic [31:0]        bad;
  } frame_result_t;

  // one row of the directed byte table
  typedef struct packed {
    logic [7:0]    rx_byte;
    logic          has_want;
    frame_result_t want;
  } directed_row_t;

  typedef enum logic [3:0] {
    HUNT_IDLE   = 4'b0001,
    HUNT_DOLLAR = 4'b0010,
    HUNT_TYPE   = 4'b0100,
    HUNT_DATA   = 4'b1000
  } hunt_state_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_frame_type;
  logic               out_checksum_ok;
  logic               out_position_valid;
  logic signed [31:0] out_latitude;
  logic signed [31:0] out_longitude;
  logic signed [31:0] out_altitude;
  logic [31:0]        out_good_frames;
  logic [31:0]        out_bad_frames;

  telemetry_frame_receiver dut (.*);

  // decoder state
  hunt_state_t hunt;
  logic [1:0]  frame_kind;
  logic [4:0]  data_pos;
  logic [7:0]  xor_acc;
  logic [7:0]  payload_img [0:13];
  logic [31:0] good_total;
  logic [31:0] bad_total;

  frame_result_t expected_frames [$];
  int            mismatch_count = 0;
  int            burst_left = 0;
  int            frame_items = 0;

  // directed bytes: gps frame with extreme fields, attitude frame with
  // header bytes in its payload and a wrong checksum, then '$' in type phase
  directed_row_t directed_bytes [0:30] = '{
    '{8'h24, 1'b0, '0}, '{8'h54, 1'b0, '0}, '{8'h47, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h80, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h7F, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b1, '{tfr_pkg::KIND_G, 1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'hFFFF_FFFF, 32'd1, 32'd0}},
    '{8'h24, 1'b0, '0}, '{8'h54, 1'b0, '0}, '{8'h41, 1'b0, '0},
    '{8'h24, 1'b0, '0}, '{8'h54, 1'b0, '0}, '{8'h41, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b1, '{tfr_pkg::KIND_A, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1}},
    '{8'h24, 1'b0, '0}, '{8'h54, 1'b0, '0}, '{8'h24, 1'b0, '0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("telemetry_frame_receiver verification failed");
    $finish;
  end

  function automatic int kind_payload_len(input logic [1:0] kind);
    case (kind)
      tfr_pkg::KIND_G: return int'(tfr_pkg::LEN_G);
      tfr_pkg::KIND_A: return int'(tfr_pkg::LEN_A);
      default:         return int'(tfr_pkg::LEN_S);
    endcase
  endfunction

  // advance the decoder by one byte, flag a finished frame
  function automatic void decode_byte(input logic [7:0] b, output logic done,
                                      output frame_result_t res);
    logic ok;
    done = 1'b0;
    res  = '0;
    case (hunt)
      HUNT_IDLE: begin
        if (b == tfr_pkg::HDR_START) hunt = HUNT_DOLLAR;
      end
      HUNT_DOLLAR: begin
        hunt = (b == tfr_pkg::HDR_SECOND) ? HUNT_TYPE : HUNT_IDLE;
      end
      HUNT_TYPE: begin
        hunt = HUNT_IDLE;
        if (b == tfr_pkg::TYPE_G || b == tfr_pkg::TYPE_A || b == tfr_pkg::TYPE_S) begin
          frame_kind = (b == tfr_pkg::TYPE_G) ? tfr_pkg::KIND_G :
                       (b == tfr_pkg::TYPE_A) ? tfr_pkg::KIND_A : tfr_pkg::KIND_S;
          hunt       = HUNT_DATA;
          data_pos   = '0;
          xor_acc    = '0;
        end
      end
      default: begin
        xor_acc = xor_acc ^ b;
        if (data_pos < kind_payload_len(frame_kind)) begin
          payload_img[data_pos] = b;
          data_pos = data_pos + 5'd1;
        end else begin
          // checksum byte closes the frame
          ok = (xor_acc == 8'h00);
          if (ok) good_total = good_total + 32'd1;
          else bad_total = bad_total + 32'd1;
          res.kind = frame_kind;
          res.ok   = ok;
          res.pos  = ok && (frame_kind == tfr_pkg::KIND_G);
          if (res.pos) begin
            res.lat = {payload_img[3], payload_img[2], payload_img[1], payload_img[0]};
            res.lon = {payload_img[7], payload_img[6], payload_img[5], payload_img[4]};
            res.alt = {payload_img[12], payload_img[11], payload_img[10], payload_img[9]};
          end
          res.good = good_total;
          res.bad  = bad_total;
          done     = 1'b1;
          hunt     = HUNT_IDLE;
          data_pos = '0;
        end
      end
    endcase
  endfunction

  // hand one item to the block in bursts, then log what it should produce
  task automatic send_byte(input logic [7:0] b, input logic has_want = 1'b0,
                           input frame_result_t want = '0);
    logic          done;
    frame_result_t res;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    decode_byte(b, done, res);
    if (has_want) expected_frames.push_back(want);
    else if (done) expected_frames.push_back(res);
  endtask

  // hold the sender until every pending result is out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: begin
        case ($urandom_range(0, 4))
          0:       return tfr_pkg::HDR_START;
          1:       return tfr_pkg::HDR_SECOND;
          2:       return tfr_pkg::TYPE_G;
          3:       return tfr_pkg::TYPE_A;
          default: return tfr_pkg::TYPE_S;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // well-formed frame with random content, checksum mostly right
  task automatic send_frame();
    logic [1:0] kind;
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    sum = 8'h00;
    case ($urandom_range(0, 2))
      0:       kind = tfr_pkg::KIND_G;
      1:       kind = tfr_pkg::KIND_A;
      default: kind = tfr_pkg::KIND_S;
    endcase
    n = kind_payload_len(kind);
    send_byte(tfr_pkg::HDR_START);
    send_byte(tfr_pkg::HDR_SECOND);
    send_byte((kind == tfr_pkg::KIND_G) ? tfr_pkg::TYPE_G :
              (kind == tfr_pkg::KIND_A) ? tfr_pkg::TYPE_A : tfr_pkg::TYPE_S);
    for (int i = 0; i < n; i++) begin
      b   = pick_byte();
      sum = sum ^ b;
      send_byte(b);
    end
    if ($urandom_range(0, 3) == 0) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
    frame_items += n + 4;
  endtask

  // header that breaks off in the second or the type phase
  task automatic send_broken_header();
    logic [7:0] b;
    send_byte(tfr_pkg::HDR_START);
    if ($urandom_range(0, 1) == 0) begin
      do b = 8'($urandom_range(0, 255)); while (b == tfr_pkg::HDR_SECOND);
      if ($urandom_range(0, 2) == 0) b = tfr_pkg::HDR_START;
    end else begin
      send_byte(tfr_pkg::HDR_SECOND);
      do b = 8'($urandom_range(0, 255));
      while (b == tfr_pkg::TYPE_G || b == tfr_pkg::TYPE_A || b == tfr_pkg::TYPE_S);
      if ($urandom_range(0, 2) == 0) b = tfr_pkg::HDR_START;
    end
    send_byte(b);
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // receiver stall pattern: quiet, light, heavy and periodic stretches
  int stall_style = 0;
  int stall_left = 0;
  int stall_tick = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(32, 256);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 7) < 3;
    endcase
  end

  // compare each accepted result with the oldest expected frame
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        report_mismatch($sformatf("result with no frame pending, type %0d",
                                  out_frame_type));
      end else begin
        want = expected_frames.pop_front();
        if (out_frame_type !== want.kind)
          report_mismatch($sformatf("frame_type %0d, want %0d", out_frame_type, want.kind));
        if (out_checksum_ok !== want.ok)
          report_mismatch($sformatf("checksum_ok %0b, want %0b", out_checksum_ok, want.ok));
        if (out_position_valid !== want.pos)
          report_mismatch($sformatf("position_valid %0b, want %0b",
                                    out_position_valid, want.pos));
        if (out_latitude !== want.lat)
          report_mismatch($sformatf("latitude %h, want %h", out_latitude, want.lat));
        if (out_longitude !== want.lon)
          report_mismatch($sformatf("longitude %h, want %h", out_longitude, want.lon));
        if (out_altitude !== want.alt)
          report_mismatch($sformatf("altitude %h, want %h", out_altitude, want.alt));
        if (out_good_frames !== want.good)
          report_mismatch($sformatf("good_frames %0d, want %0d", out_good_frames, want.good));
        if (out_bad_frames !== want.bad)
          report_mismatch($sformatf("bad_frames %0d, want %0d", out_bad_frames, want.bad));
      end
    end
  end

  // main sequence
  initial begin
    int loop_count;
    hunt       = HUNT_IDLE;
    frame_kind = '0;
    data_pos   = '0;
    xor_acc    = '0;
    good_total = '0;
    bad_total  = '0;
    loop_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_bytes[i])
      send_byte(directed_bytes[i].rx_byte, directed_bytes[i].has_want,
                directed_bytes[i].want);
    drain_results();

    // random frames, noise and broken headers
    while (frame_items < 2000) begin
      loop_count++;
      case ($urandom_range(0, 9))
        0:       repeat ($urandom_range(1, 6)) send_byte(pick_byte());
        1:       send_broken_header();
        default: send_frame();
      endcase
      if (loop_count % 50 == 0) drain_results();
    end

    // let the last results out
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("telemetry_frame_receiver verification clean");
    end else begin
      $display("telemetry_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
